### design/zzrt_pkg.sv
// zzrt_pkg: shared widths, sequencer state type and read-control struct
// for the zigzag row transposer. Depends on nothing; compile first.
package zzrt_pkg;

	localparam int CHAR_W = 8;
	localparam int ROW_W  = 7;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SETUP,
		ST_EMIT
	} zzrt_state_t;

	typedef struct packed {
		logic rd_en;
		logic last;
	} zzrt_rd_ctl_t;

endpackage

### design/zzrt_ifs.sv
// zzrt_ifs: valid/ready word channels for message bytes in and transposed
// bytes out. Depends on zzrt_pkg.
interface zzrt_in_if;
	import zzrt_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;
	logic              msg_end;

	modport source (output valid, output char_in, output msg_end, input ready);
	modport sink   (input valid, input char_in, input msg_end, output ready);
endinterface

interface zzrt_out_if;
	import zzrt_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              run_end;

	modport source (output valid, output char_out, output run_end, input ready);
	modport sink   (input valid, input char_out, input run_end, output ready);
endinterface

### design/zzrt_store.sv
// zzrt_store: message byte buffer, one write port and one read port with
// registered read data. Depends on zzrt_pkg.
module zzrt_store #(
	parameter int MAX_LEN = 64,
	localparam int AW = $clog2(MAX_LEN)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [zzrt_pkg::CHAR_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [zzrt_pkg::CHAR_W-1:0] rd_data
);
	import zzrt_pkg::*;

	logic [CHAR_W-1:0] mem [MAX_LEN];
	logic [CHAR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/zzrt_seq.sv
// zzrt_seq: load counter and zigzag address sequencer. Needs zzrt_pkg.
// Forms and range-checks a candidate per cycle; a hit awaits out_free.
module zzrt_seq #(
	parameter int MAX_LEN = 64,
	localparam int AW = $clog2(MAX_LEN),
	localparam int LEN_W = $clog2(MAX_LEN + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [zzrt_pkg::ROW_W-1:0]    row_count,
	input  logic                          in_valid,
	input  logic                          msg_end,
	output logic                          in_ready,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	input  logic                          out_free,
	output zzrt_pkg::zzrt_rd_ctl_t        rd_ctl,
	output logic [AW-1:0]                 rd_addr
);
	import zzrt_pkg::*;

	localparam int CW = ((ROW_W > LEN_W) ? ROW_W : LEN_W) + 2;

	zzrt_state_t state_q, state_d;
	logic [LEN_W-1:0] len_q, n_q, k_q;
	logic [CW-1:0]    rows_q, period_q, r_q, p_q;
	logic             phase_q;

	logic             accept, room, straight, mid, hit, step, row_done, all_done;
	logic [CW-1:0]    rows_ext, n_ext, off, cand, p_adv, r_inc;
	logic [LEN_W-1:0] len_fin;

	always_comb begin
		accept   = in_valid && in_ready;
		room     = len_q < LEN_W'(MAX_LEN);
		len_fin  = room ? len_q + 1'b1 : len_q;
		rows_ext = CW'(row_count);
		n_ext    = CW'(n_q);
		straight = (rows_ext <= CW'(1)) || (rows_ext >= n_ext);
		mid      = (r_q != '0) && (r_q != rows_q - 1'b1);
		// shared adder: position of this candidate
		off      = phase_q ? period_q - r_q : r_q;
		cand     = p_q + off;
		hit      = cand < n_ext;
		step     = (state_q == ST_EMIT) && (!hit || out_free);
		p_adv    = p_q + period_q;
		r_inc    = r_q + 1'b1;
		row_done = p_adv >= n_ext;
		all_done = !(!phase_q && mid) && row_done && (r_inc == rows_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && msg_end) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (step && all_done) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_LOAD);
		wr_en        = accept && room;
		wr_addr      = len_q[AW-1:0];
		rd_ctl.rd_en = step && hit;
		rd_ctl.last  = (k_q + 1'b1) == n_q;
		rd_addr      = cand[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			len_q    <= '0;
			n_q      <= '0;
			k_q      <= '0;
			rows_q   <= '0;
			period_q <= '0;
			r_q      <= '0;
			p_q      <= '0;
			phase_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				len_q <= msg_end ? '0 : len_fin;
				if (msg_end) begin
					n_q <= len_fin;
				end
			end
			if (state_q == ST_SETUP) begin
				rows_q   <= straight ? CW'(1) : rows_ext;
				period_q <= straight ? CW'(1) : CW'((rows_ext - 1'b1) << 1);
				r_q      <= '0;
				p_q      <= '0;
				phase_q  <= 1'b0;
				k_q      <= '0;
			end
			if (step) begin
				if (hit) begin
					k_q <= k_q + 1'b1;
				end
				if (!phase_q && mid) begin
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					if (row_done) begin
						p_q <= '0;
						r_q <= r_inc;
					end else begin
						p_q <= p_adv;
					end
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_rd_in_msg: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ctl.rd_en |-> (CW'(rd_addr) < n_ext))
		else $error("read beyond message length");
	a_run_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(step && all_done) |-> ((k_q + LEN_W'(hit)) == n_q))
		else $error("run ended with a wrong word count");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LEN))
		else $error("fill count past buffer depth");
	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !wr_en)
		else $error("buffer written during a run");
`endif

endmodule

### design/zigzag_row_transposer_unit.sv
// Timing: a message byte is taken per cycle while loading; once the end-marked byte is
// taken the sequencer passes a setup state, then reads the first transposed word.
// Runs: the input stays closed until the run ends (a setup state, then one candidate
// position per cycle, an in-range one waiting while the held output word is not taken).
// Reset: arst_n clears the fill count, sequencer and output valid; row_count
// returns to 1. Buffer contents stay undefined until written.
module zigzag_row_transposer_unit #(
	parameter int MAX_LEN = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [zzrt_pkg::ROW_W-1:0] cfg_wdata,
	zzrt_in_if.sink                    in_ch,
	zzrt_out_if.source                 out_ch
);
	import zzrt_pkg::*;

	localparam int AW = $clog2(MAX_LEN);

	logic [ROW_W-1:0]  row_count_q;
	logic              out_valid_q;
	logic              run_end_q;
	logic              out_free;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [CHAR_W-1:0] rd_data;
	zzrt_rd_ctl_t      rd_ctl;

	// row count register; the user must write it only while the block is idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_W'(1);
		end else if (cfg_we) begin
			row_count_q <= cfg_wdata;
		end
	end

	// the store's read register is the output word; a new read may land
	// only once the held word has gone
	assign out_free = !out_valid_q || out_ch.ready;

	zzrt_seq #(
		.MAX_LEN(MAX_LEN)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.row_count(row_count_q),
		.in_valid (in_ch.valid),
		.msg_end  (in_ch.msg_end),
		.in_ready (in_ch.ready),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.out_free (out_free),
		.rd_ctl   (rd_ctl),
		.rd_addr  (rd_addr)
	);

	zzrt_store #(
		.MAX_LEN(MAX_LEN)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(in_ch.char_in),
		.rd_en  (rd_ctl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// output valid and end mark travel alongside the read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_end_q   <= 1'b0;
		end else if (rd_ctl.rd_en) begin
			out_valid_q <= 1'b1;
			run_end_q   <= rd_ctl.last;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.char_out = rd_data;
	assign out_ch.run_end  = run_end_q;

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !rd_ctl.rd_en)
		else $error("held output word overwritten");
	// the final read may still be followed by one out-of-range candidate
	a_end_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_ctl.rd_en && rd_ctl.last) |-> ##[1:2] in_ch.ready)
		else $error("input not reopened after final word");
	a_no_word_loading: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !rd_ctl.rd_en)
		else $error("read issued while loading");
`endif

endmodule

### tb/zigzag_row_transposer_unit_tb.sv
`timescale 1ns / 1ps
// zigzag_row_transposer_unit_tb: self-checking bench for the rail fence transposer.
// A queue-fed word driver and a checking monitor run against a behavioural predictor.
// Depends on zzrt_pkg, zzrt_ifs and zigzag_row_transposer_unit.
module zigzag_row_transposer_unit_tb;
	import zzrt_pkg::*;

	localparam int MAX_LEN       = 64;
	localparam int RAND_WORDS    = 210;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [CHAR_W-1:0] char_in;
		logic              msg_end;
	} msg_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              run_end;
	} rail_word_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [ROW_W-1:0] cfg_wdata;

	zzrt_in_if  in_ch ();
	zzrt_out_if out_ch ();

	zigzag_row_transposer_unit #(
		.MAX_LEN(MAX_LEN)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// Words waiting to be driven, and transposed words still owed by the block.
	msg_word_t  word_q[$];
	rail_word_t rail_q[$];
	msg_word_t  next_w;

	// Predictor state: the message store, its fill count and the row setting.
	logic [CHAR_W-1:0] msg_mem [MAX_LEN];
	int                fill     = 0;
	logic [ROW_W-1:0]  rows_cfg = 1;

	logic        in_fire = 1'b0;
	int unsigned send_idle_pct = 35;
	int unsigned recv_idle_pct = 47;
	int          errors     = 0;
	int          n_results  = 0;
	int          n_queued   = 0;
	int          n_msgs     = 0;
	int          n_settings = 0;
	int          cycles     = 0;
	int          rand_base;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Store one accepted byte; on the end mark, work out the whole transposed run.
	// Rows are visited top to bottom; a middle row takes two bytes per period.
	task automatic absorb_byte(input logic [CHAR_W-1:0] ch, input logic last);
		int         n;
		int         rows;
		int         per;
		int         pos_q[$];
		rail_word_t w;
		if (fill < MAX_LEN) begin
			msg_mem[fill] = ch;
			fill++;
		end
		// Bytes past a full store are dropped, but their end mark still counts.
		if (!last)
			return;
		n    = fill;
		rows = int'(rows_cfg);
		fill = 0;
		if (rows <= 1 || rows >= n) begin
			// Too few or too many rows: the message passes through unchanged.
			for (int p = 0; p < n; p++)
				pos_q.push_back(p);
		end else begin
			per = 2 * (rows - 1);
			for (int r = 0; r < rows; r++) begin
				for (int p = 0; p < n; p += per) begin
					if (p + r < n)
						pos_q.push_back(p + r);
					if (r != 0 && r != rows - 1 && p + per - r < n)
						pos_q.push_back(p + per - r);
				end
			end
		end
		foreach (pos_q[i]) begin
			w.char_out = msg_mem[pos_q[i]];
			w.run_end  = (i == pos_q.size() - 1);
			rail_q.push_back(w);
		end
	endtask

	task automatic queue_word(input logic [CHAR_W-1:0] ch, input logic last);
		msg_word_t w;
		w.char_in = ch;
		w.msg_end = last;
		word_q.push_back(w);
		n_queued++;
		if (last)
			n_msgs++;
	endtask

	task automatic queue_message(input int len);
		for (int i = 0; i < len; i++)
			queue_word(CHAR_W'($urandom_range(255)), i == len - 1);
	endtask

	// Hold until every word is in and every owed word is out, then let the
	// sequencer wind down before anything else touches the block.
	task automatic settle_idle();
		while (word_q.size() != 0 || in_ch.valid || rail_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rows(input int v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ROW_W'(v);
		@(negedge clk);
		cfg_we    <= 1'b0;
		n_settings++;
	endtask

	// Sender: offer the next word at the falling edge once the current one is
	// taken; idle at random in between. Hold the word while it is refused.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_fire) begin
			if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_w = word_q.pop_front();
				in_ch.valid   <= 1'b1;
				in_ch.char_in <= next_w.char_in;
				in_ch.msg_end <= next_w.msg_end;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random, and hold ready low during reset.
	always @(negedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: everything is sampled at the rising edge, before the block's
	// own updates land. Track register writes, feed accepted bytes to the
	// predictor and check each transposed word against the oldest one owed.
	always @(posedge clk) begin
		rail_word_t got;
		rail_word_t exp_w;
		if (cfg_we)
			rows_cfg = cfg_wdata;
		in_fire = in_ch.valid && in_ch.ready;
		if (in_fire)
			absorb_byte(in_ch.char_in, in_ch.msg_end);
		if (out_ch.valid && out_ch.ready) begin
			got.char_out = out_ch.char_out;
			got.run_end  = out_ch.run_end;
			if (rail_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual char_out=%02h run_end=%0b",
					$time, got.char_out, got.run_end);
			end else begin
				exp_w = rail_q.pop_front();
				n_results++;
				if (got.char_out !== exp_w.char_out || got.run_end !== exp_w.run_end) begin
					errors++;
					$display("%0t: mismatch: expected char_out=%02h run_end=%0b, actual char_out=%02h run_end=%0b",
						$time, exp_w.char_out, exp_w.run_end, got.char_out, got.run_end);
				end
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words still owed", $time, rail_q.size());
			$display("** zigzag_row_transposer_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		in_ch.valid   = 1'b0;
		in_ch.char_in = '0;
		in_ch.msg_end = 1'b0;
		out_ch.ready  = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		arst_n        = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset row setting first, byte extremes, a lone end-marked byte.
		queue_word(8'h00, 1'b1);
		queue_word(8'hFF, 1'b0);
		queue_word(8'hA5, 1'b0);
		queue_word(8'h5A, 1'b1);
		settle_idle();
		// Two and three rows: the plainest real zigzags.
		write_rows(2);
		queue_message(5);
		settle_idle();
		write_rows(3);
		queue_message(6);
		settle_idle();
		// Zero rows and the top of the register both pass the message through.
		write_rows(0);
		queue_message(3);
		settle_idle();
		write_rows(127);
		queue_message(4);
		settle_idle();
		// Rows equal to the length: unchanged too.
		write_rows(4);
		queue_message(4);
		settle_idle();

		// Overflow: the end mark arrives on a dropped byte.
		rand_base = n_queued;
		write_rows(5);
		queue_message(66);

		// Random phases: new row setting each time, one to three messages,
		// mostly short ones. Swap the stall pattern after a third, then run free.
		while (n_queued - rand_base < RAND_WORDS) begin
			settle_idle();
			if (n_queued - rand_base >= 2 * RAND_WORDS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (n_queued - rand_base >= RAND_WORDS / 3) begin
				send_idle_pct = 47;
				recv_idle_pct = 35;
			end
			case ($urandom_range(9))
				0: write_rows(0);
				1: write_rows(1);
				2: write_rows(64);
				3: write_rows(127);
				4: write_rows(63);
				5: write_rows(int'($urandom_range(127)));
				default: write_rows(int'($urandom_range(2, 12)));
			endcase
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(99)) inside
					[0:69]:  queue_message($urandom_range(1, 10));
					[70:87]: queue_message($urandom_range(11, 40));
					[88:95]: queue_message($urandom_range(41, 64));
					default: queue_message($urandom_range(65, 72));
				endcase
			end
		end

		settle_idle();
		if (rail_q.size() != 0) begin
			errors += rail_q.size();
			$display("%0t: %0d transposed words never arrived", $time, rail_q.size());
		end
		$display("Run covered %0d messages (%0d bytes) over %0d row settings, %0d words checked.",
			n_msgs, n_queued, n_settings, n_results);
		$display("Both channels stalled in turn, then ran free; %0d errors.", errors);
		if (errors == 0) begin
			$display("** zigzag_row_transposer_unit: PASSED **");
		end else begin
			$display("** zigzag_row_transposer_unit: FAILED **");
		end
		$finish;
	end

endmodule

### filelist.f
design/zzrt_pkg.sv
design/zzrt_ifs.sv
design/zzrt_store.sv
design/zzrt_seq.sv
design/zigzag_row_transposer_unit.sv
tb/zigzag_row_transposer_unit_tb.sv
